### rtl/core/sdtq_pkg.sv
// ---------------------------------------------------------------------------
// sdtq_pkg: shared types and constants of the sorted deadline timer queue
// Field widths, command and result codes, and the cell entry record.
// ---------------------------------------------------------------------------
`default_nettype none
package sdtq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int MIN_DUR_W    = 20;
	localparam int OVERDUE_W    = 16;
	localparam int CFG_W        = 20;
	localparam int CFG_IDX_W    = 1;
	localparam logic [19:0] MIN_DUR_RST = 20'd1000;
	localparam logic [15:0] OVERDUE_RST = 16'd10;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_ADD   = 2'd1;
	localparam logic [1:0] KIND_DEL   = 2'd2;
	localparam logic [1:0] KIND_QUERY = 2'd3;

	localparam logic [1:0] RES_EXPIRED  = 2'd0;
	localparam logic [1:0] RES_INTERVAL = 2'd1;
	localparam logic [1:0] RES_STATUS   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;

	localparam logic CFG_MIN_DUR = 1'b0;
	localparam logic CFG_OVERDUE = 1'b1;

	// One timer as held in a cell
	typedef struct packed {
		logic [31:0] deadline;
		logic [30:0] duration;
		logic [7:0]  owner;
		logic [31:0] tag;
		logic        periodic;
	} entry_t;

	// Broadcast command from the controller to every cell
	typedef struct packed {
		logic   ins;      // insert ent at sorted position
		logic   del;      // remove the first matching cell
		logic   pop;      // remove the head cell
		entry_t ent;
	} cell_cmd_t;

	// a is not later than b in modular time
	function automatic logic not_later(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return ~d[31];
	endfunction

endpackage
`default_nettype wire

### rtl/core/sdtq_cell.sv
// ---------------------------------------------------------------------------
// sdtq_cell: one slot of the sorted timer chain
// Holds one entry and shifts toward the head or tail with its neighbors.
// ---------------------------------------------------------------------------
`default_nettype none
module sdtq_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  sdtq_pkg::cell_cmd_t   cmd,
	input  sdtq_pkg::entry_t      prev_ent,    // cell toward the head
	input  wire                   prev_valid,
	input  wire                   prev_later,  // prev cell holds a later deadline
	input  wire                   prev_hit,    // a cell ahead matches the delete key
	input  sdtq_pkg::entry_t      next_ent,    // cell toward the tail
	input  wire                   next_valid,
	output sdtq_pkg::entry_t      ent,
	output logic                  valid,
	output logic                  later,
	output logic                  hit_out
);

	sdtq_pkg::entry_t ent_q;
	logic             valid_q;
	logic             hit;

	// new entry goes before this one when this deadline is strictly later
	assign later   = valid_q & ~sdtq_pkg::not_later(ent_q.deadline, cmd.ent.deadline);
	assign hit     = valid_q & (ent_q.owner == cmd.ent.owner)
	                 & (ent_q.duration == cmd.ent.duration);
	assign hit_out = prev_hit | hit;
	assign ent     = ent_q;
	assign valid   = valid_q;

	// hold valid flag; an insert fills the first empty cell behind the tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			valid_q <= valid_q | prev_valid;
		end else if (cmd.pop || (cmd.del && (prev_hit || hit))) begin
			valid_q <= next_valid;
		end
	end

	// shift payload
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (prev_later) ent_q <= prev_ent;
			else if (later || !valid_q) ent_q <= cmd.ent;
		end else if (cmd.pop || (cmd.del && (prev_hit || hit))) begin
			ent_q <= next_ent;
		end
	end

endmodule
`default_nettype wire

### rtl/core/sorted_deadline_timer_queue.sv
// ---------------------------------------------------------------------------
// sorted_deadline_timer_queue: deadline-ordered timer store
// Chain of cells sorted by deadline with a command sequencer in front.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction (tick, add, delete, query).
//   m_axis returns the results; tlast marks the final result of a command.
//   Add, delete and query: the accepting edge updates the cell chain and
//   the next edge loads the output register; once the receiver takes the
//   result, the input opens again.
//   A tick advances time, then drops each due owner-zero entry, pops and
//   emits each other due entry (the result drains while a periodic timer
//   is re-inserted), sees the head not due, loads the interval and
//   transfers it.
//   A command is accepted only when the previous one has finished and the
//   output register is empty, so a stalled receiver holds pops and input.
//   Reset empties the chain, zeroes the time base and loads the default
//   minimum duration (1000) and overdue interval (10).
//   Configuration writes through cfg_we/cfg_idx/cfg_data are registered at
//   once, so a query not yet answered already uses a new overdue interval.
// ---------------------------------------------------------------------------
`default_nettype none
module sorted_deadline_timer_queue #(
	parameter int CAPACITY = sdtq_pkg::CAPACITY_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [71:0] s_axis_tdata,   // owner, periodic, duration, tag
	input  wire  [1:0]  s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [111:0] m_axis_tdata,  // owner_res, periodic_res, duration_res,
	                                    // tag_res, interval, status
	output logic [1:0]  m_axis_tuser,   // result_kind
	output logic        m_axis_tlast,   // last
	input  wire         cfg_we,
	input  wire  [sdtq_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire  [sdtq_pkg::CFG_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {S_IDLE, S_POP, S_OUT} state_t;

	state_t                 state_q;
	logic [19:0]            min_dur_q;
	logic [15:0]            overdue_q;
	logic [31:0]            now_q;
	logic [CNT_W-1:0]       count_q;
	logic [1:0]             kind_q;
	logic [1:0]             status_q;
	logic                   res_full_q;
	logic [1:0]             rkind_q;
	logic [111:0]           rdata_q;
	logic                   rlast_q;

	sdtq_pkg::cell_cmd_t    cmd;
	sdtq_pkg::entry_t       ent   [CAPACITY];
	logic                   vld   [CAPACITY];
	logic                   lat   [CAPACITY];
	logic                   hitv  [CAPACITY];
	sdtq_pkg::entry_t       pend_q;
	sdtq_pkg::entry_t       rearm_ent;
	logic                   pend_ins_q;

	wire accept = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) & ~res_full_q;

	// chain of cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		sdtq_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.prev_ent  ((g == 0) ? cmd.ent : ent[(g == 0) ? 0 : g-1]),
			.prev_valid((g == 0) ? 1'b1 : vld[(g == 0) ? 0 : g-1]),
			.prev_later((g == 0) ? 1'b0 : lat[(g == 0) ? 0 : g-1]),
			.prev_hit  ((g == 0) ? 1'b0 : hitv[(g == 0) ? 0 : g-1]),
			.next_ent  ((g == CAPACITY-1) ? ent[g] : ent[(g == CAPACITY-1) ? g : g+1]),
			.next_valid((g == CAPACITY-1) ? 1'b0 : vld[(g == CAPACITY-1) ? g : g+1]),
			.ent(ent[g]), .valid(vld[g]), .later(lat[g]), .hit_out(hitv[g])
		);
	end

	// decode incoming command
	logic [30:0] in_dur, clamp_dur, minimum;
	assign in_dur    = s_axis_tdata[39:9];
	assign minimum   = (min_dur_q == '0) ? 31'd1 : {11'd0, min_dur_q};
	assign clamp_dur = (in_dur < minimum) ? minimum : in_dur;
	wire full = (count_q == CNT_W'(CAPACITY));

	wire head_due = vld[0] & sdtq_pkg::not_later(ent[0].deadline, now_q);

	// re-armed copy of the head timer
	always_comb begin
		rearm_ent          = ent[0];
		rearm_ent.deadline = now_q + {1'b0, ent[0].duration};
	end

	always_comb begin
		cmd = '0;
		if (state_q == S_IDLE && accept) begin
			cmd.ent.owner    = s_axis_tdata[7:0];
			cmd.ent.periodic = s_axis_tdata[8];
			cmd.ent.tag      = s_axis_tdata[71:40];
			unique case (s_axis_tuser)
				sdtq_pkg::KIND_ADD: begin
					cmd.ent.duration = clamp_dur;
					cmd.ent.deadline = now_q + {1'b0, clamp_dur};
					cmd.ins = ~full;
				end
				sdtq_pkg::KIND_DEL: begin
					cmd.ent.duration = in_dur;
					cmd.del = 1'b1;
				end
				default: ;
			endcase
		end else if (state_q == S_POP) begin
			if (pend_ins_q) begin
				cmd.ent = pend_q;
				cmd.ins = 1'b1;
			end else if (head_due && !res_full_q) begin
				cmd.pop = 1'b1;
			end
		end
	end

	wire any_hit = hitv[CAPACITY-1];

	// sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			min_dur_q  <= sdtq_pkg::MIN_DUR_RST;
			overdue_q  <= sdtq_pkg::OVERDUE_RST;
			now_q      <= '0;
			count_q    <= '0;
			kind_q     <= sdtq_pkg::KIND_TICK;
			status_q   <= sdtq_pkg::ST_OK;
			res_full_q <= 1'b0;
			pend_ins_q <= 1'b0;
			rkind_q    <= sdtq_pkg::RES_EXPIRED;
			rlast_q    <= 1'b0;
			rdata_q    <= '0;
			pend_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					sdtq_pkg::CFG_MIN_DUR: min_dur_q <= cfg_data[19:0];
					sdtq_pkg::CFG_OVERDUE: overdue_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) res_full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					kind_q <= s_axis_tuser;
					unique case (s_axis_tuser)
						sdtq_pkg::KIND_TICK: begin
							now_q   <= now_q + 32'd1;
							state_q <= S_POP;
						end
						sdtq_pkg::KIND_ADD: begin
							status_q <= full ? sdtq_pkg::ST_FULL : sdtq_pkg::ST_OK;
							if (!full) count_q <= count_q + 1'b1;
							state_q <= S_OUT;
						end
						sdtq_pkg::KIND_DEL: begin
							status_q <= any_hit ? sdtq_pkg::ST_OK : sdtq_pkg::ST_NOMATCH;
							if (any_hit) count_q <= count_q - 1'b1;
							state_q <= S_OUT;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_POP: begin
					if (pend_ins_q) begin
						pend_ins_q <= 1'b0;
						count_q    <= count_q + 1'b1;
					end else if (cmd.pop) begin
						count_q <= count_q - 1'b1;
						if (ent[0].owner != 8'd0) begin
							res_full_q <= 1'b1;
							rkind_q    <= sdtq_pkg::RES_EXPIRED;
							rlast_q    <= 1'b0;
							rdata_q    <= {6'd0, 2'd0, 32'd0, ent[0].tag, ent[0].duration,
							               ent[0].periodic, ent[0].owner};
							if (ent[0].periodic) begin
								pend_ins_q <= 1'b1;
								pend_q     <= rearm_ent;
							end
						end
					end else if (!head_due) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: if (!res_full_q) begin
					res_full_q <= 1'b1;
					rlast_q    <= 1'b1;
					state_q    <= S_IDLE;
					if (kind_q == sdtq_pkg::KIND_ADD || kind_q == sdtq_pkg::KIND_DEL) begin
						rkind_q <= sdtq_pkg::RES_STATUS;
						rdata_q <= {6'd0, status_q, 104'd0};
					end else begin
						rkind_q <= sdtq_pkg::RES_INTERVAL;
						if (!vld[0])
							rdata_q <= '0;
						else if (kind_q == sdtq_pkg::KIND_QUERY && head_due)
							rdata_q <= {6'd0, 2'd0, 16'd0, overdue_q, 72'd0};
						else
							rdata_q <= {6'd0, 2'd0, ent[0].deadline - now_q, 72'd0};
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = res_full_q;
	assign m_axis_tdata  = rdata_q;
	assign m_axis_tuser  = rkind_q;
	assign m_axis_tlast  = rlast_q;

endmodule
`default_nettype wire

### rtl/core/sdtq_checker.sv
// ---------------------------------------------------------------------------
// sdtq_checker: port-level checks of the timer queue
// Watches the stream ports for ordering and handshake slips.
// ---------------------------------------------------------------------------
`default_nettype none
module sdtq_port_checks (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [1:0]  m_axis_tuser,
	input wire        m_axis_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped under stall");

	// expired results never end a command
	a_exp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == sdtq_pkg::RES_EXPIRED |-> !m_axis_tlast)
		else $error("expired result marked last");

	// no new command while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("command taken while result pending");

	// final results are interval or status
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser != sdtq_pkg::RES_EXPIRED)
		else $error("bad final result kind");

endmodule

bind sorted_deadline_timer_queue sdtq_port_checks u_sdtq_port_checks (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

### tb/sdtq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdtq_checker: result predictor and scoreboard for the timer queue
// Watches the command, result and register write channels, keeps its own
// copy of the sorted timer store, and compares every result transaction
// field by field with the oldest expected one.
// ---------------------------------------------------------------------------
module sdtq_checker
	import sdtq_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	input  wire          s_tready,
	input  wire  [71:0]  s_tdata,   // owner, periodic, duration, tag
	input  wire  [1:0]   s_tuser,   // kind
	input  wire          m_tvalid,
	input  wire          m_tready,
	input  wire  [111:0] m_tdata,   // owner_res, periodic_res, duration_res,
	                                // tag_res, interval, status
	input  wire  [1:0]   m_tuser,   // result_kind
	input  wire          m_tlast,   // last
	input  wire          cfg_we,
	input  wire  [CFG_IDX_W-1:0] cfg_idx,
	input  wire  [CFG_W-1:0]     cfg_data,
	output int           errors,
	output int           pending,
	output int           checked
);

	localparam int DEPTH = CAPACITY_DEF;

	typedef struct {
		logic [1:0]  rkind;
		logic [7:0]  owner;
		logic        periodic;
		logic [30:0] duration;
		logic [31:0] tag;
		logic [31:0] interval;
		logic [1:0]  status;
		logic        last;
	} timer_result_t;

	timer_result_t expected_results[$];

	// Shadow of the block state
	logic [31:0] now_ticks;
	entry_t      timers[DEPTH];
	int          timer_count;
	logic [19:0] min_dur;
	logic [15:0] overdue_ivl;

	assign pending = expected_results.size();

	// a is due no later than b when b - a lands in the lower half of the range
	function automatic bit due_by(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = b - a;
		return diff < 32'h8000_0000;
	endfunction

	task automatic insert_timer(input entry_t e, output bit ok);
		int pos;
		pos = 0;
		ok = 0;
		if (timer_count < DEPTH) begin
			while (pos < timer_count && due_by(timers[pos].deadline, e.deadline))
				pos++;
			for (int i = timer_count; i > pos; i--)
				timers[i] = timers[i-1];
			timers[pos] = e;
			timer_count++;
			ok = 1;
		end
	endtask

	task automatic remove_timer(input int pos);
		for (int i = pos; i + 1 < timer_count; i++)
			timers[i] = timers[i+1];
		timer_count--;
	endtask

	task automatic push_result(input logic [1:0] rk, input entry_t e,
			input logic [31:0] ivl, input logic [1:0] st, input logic lst);
		timer_result_t r;
		r.rkind    = rk;
		r.owner    = e.owner;
		r.periodic = e.periodic;
		r.duration = e.duration;
		r.tag      = e.tag;
		r.interval = ivl;
		r.status   = st;
		r.last     = lst;
		expected_results.push_back(r);
	endtask

	// Apply one accepted command to the shadow store and queue its results
	task automatic predict_command(input logic [1:0] kind, input logic [7:0] own,
			input logic per, input logic [30:0] dur, input logic [31:0] tg);
		entry_t      blank, head, e;
		logic [30:0] floor_dur, d;
		logic [31:0] ivl;
		logic [1:0]  st;
		bit          ok;
		blank = '0;
		ivl = '0;
		floor_dur = (min_dur == 0) ? 31'd1 : {11'd0, min_dur};
		case (kind)
			KIND_TICK: begin
				now_ticks = now_ticks + 1;
				for (int g = 0; g < DEPTH && timer_count > 0; g++) begin
					if (!due_by(timers[0].deadline, now_ticks))
						break;
					head = timers[0];
					remove_timer(0);
					if (head.owner != 0) begin
						push_result(RES_EXPIRED, head, '0, ST_OK, 1'b0);
						if (head.periodic) begin
							head.deadline = now_ticks + {1'b0, head.duration};
							insert_timer(head, ok);
						end
					end
				end
				if (timer_count > 0)
					ivl = timers[0].deadline - now_ticks;
				push_result(RES_INTERVAL, blank, ivl, ST_OK, 1'b1);
			end
			KIND_ADD: begin
				d = (dur < floor_dur) ? floor_dur : dur;
				e.deadline = now_ticks + {1'b0, d};
				e.duration = d;
				e.owner    = own;
				e.tag      = tg;
				e.periodic = per;
				insert_timer(e, ok);
				push_result(RES_STATUS, blank, '0, ok ? ST_OK : ST_FULL, 1'b1);
			end
			KIND_DEL: begin
				st = ST_NOMATCH;
				for (int i = 0; i < timer_count; i++) begin
					if (timers[i].owner == own && timers[i].duration == dur) begin
						remove_timer(i);
						st = ST_OK;
						break;
					end
				end
				push_result(RES_STATUS, blank, '0, st, 1'b1);
			end
			default: begin
				if (timer_count > 0) begin
					if (due_by(timers[0].deadline, now_ticks))
						ivl = {16'd0, overdue_ivl};
					else
						ivl = timers[0].deadline - now_ticks;
				end
				push_result(RES_INTERVAL, blank, ivl, ST_OK, 1'b1);
			end
		endcase
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field,
			got, want);
		errors++;
	endtask

	// Track register writes, commands and results on every edge
	always @(posedge clk or negedge arst_n) begin
		timer_result_t w;
		if (!arst_n) begin
			now_ticks   <= '0;
			timer_count <= 0;
			min_dur     <= MIN_DUR_RST;
			overdue_ivl <= OVERDUE_RST;
			errors      <= 0;
			checked     <= 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_MIN_DUR)
					min_dur = cfg_data[MIN_DUR_W-1:0];
				else
					overdue_ivl = cfg_data[OVERDUE_W-1:0];
			end
			if (s_tvalid && s_tready)
				predict_command(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[39:9],
					s_tdata[71:40]);
			if (m_tvalid && m_tready) begin
				checked++;
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result transaction, kind %0d", $realtime,
						m_tuser);
					errors++;
				end else begin
					w = expected_results.pop_front();
					if (m_tuser != w.rkind)
						report_mismatch("result_kind", m_tuser, w.rkind);
					if (m_tdata[7:0] != w.owner)
						report_mismatch("owner", m_tdata[7:0], w.owner);
					if (m_tdata[8] != w.periodic)
						report_mismatch("periodic", m_tdata[8], w.periodic);
					if (m_tdata[39:9] != w.duration)
						report_mismatch("duration", m_tdata[39:9], w.duration);
					if (m_tdata[71:40] != w.tag)
						report_mismatch("tag", m_tdata[71:40], w.tag);
					if (m_tdata[103:72] != w.interval)
						report_mismatch("interval", m_tdata[103:72], w.interval);
					if (m_tdata[105:104] != w.status)
						report_mismatch("status", m_tdata[105:104], w.status);
					if (m_tlast != w.last)
						report_mismatch("last", m_tlast, w.last);
				end
			end
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: stimulus top for the sorted deadline timer queue
// Drives directed and random timer commands with random gaps and output
// stalls across several register settings; the checker does the scoring.
// ---------------------------------------------------------------------------
module tb;
	import sdtq_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD  = 300;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [71:0]  s_tdata;   // owner, periodic, duration, tag
	logic [1:0]   s_tuser;   // kind
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;   // owner_res, periodic_res, duration_res,
	                         // tag_res, interval, status
	logic [1:0]   m_tuser;   // result_kind
	logic         m_tlast;   // last
	logic         cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	int errors, pending, checked;
	int sent;
	int idle_cycles;
	bit send_quiet, recv_quiet, hold_req;
	logic [19:0] cur_min;

	// Owner/duration pairs of timers added, used as delete keys
	logic [38:0] added_keys[$];

	sorted_deadline_timer_queue uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
		.m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser), .m_axis_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	sdtq_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result receiver: random stalls, quiet stretches, one long hold
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 0;
			end else begin
				if ($urandom_range(0, 29) == 0)
					recv_quiet = ~recv_quiet;
				gap = recv_quiet ? 0 : $urandom_range(0, 16);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_cmd(input logic [1:0] kind, input logic [7:0] own,
			input logic per, input logic [30:0] dur, input logic [31:0] tg);
		int gap;
		if ($urandom_range(0, 29) == 0)
			send_quiet = ~send_quiet;
		gap = send_quiet ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {tg, dur, per, own};
		s_tuser  <= kind;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Add a timer and remember its stored (clamped) key for later deletes
	task automatic arm_timer(input logic [7:0] own, input logic per,
			input logic [30:0] dur, input logic [31:0] tg);
		logic [30:0] floor_dur;
		floor_dur = (cur_min == 0) ? 31'd1 : {11'd0, cur_min};
		send_cmd(KIND_ADD, own, per, dur, tg);
		added_keys.push_back({own, (dur < floor_dur) ? floor_dur : dur});
	endtask

	// Drain all results, let the block settle, then write a register
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MIN_DUR)
			cur_min = val;
	endtask

	task automatic random_cmds(input int n);
		int r, k;
		logic [30:0] dur;
		logic [38:0] key;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, 99);
			dur = (k < 85) ? 31'($urandom_range(0, 24)) :
				(k < 95) ? 31'($urandom_range(0, 2000)) : 31'($urandom);
			if (r < 40)
				send_cmd(KIND_TICK, 8'($urandom), 1'($urandom), 31'($urandom), $urandom);
			else if (r < 70)
				arm_timer(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom),
					1'($urandom_range(0, 1)), dur, $urandom);
			else if (r < 85) begin
				if (added_keys.size() > 0 && $urandom_range(0, 9) < 7) begin
					k = $urandom_range(0, added_keys.size() - 1);
					key = added_keys[k];
					added_keys.delete(k);
					send_cmd(KIND_DEL, key[38:31], 1'($urandom), key[30:0], $urandom);
				end else
					send_cmd(KIND_DEL, 8'($urandom), 1'($urandom), dur, $urandom);
			end else
				send_cmd(KIND_QUERY, 8'($urandom), 1'($urandom), 31'($urandom), $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_TICK;
		cfg_we = 1'b0;
		cfg_idx = CFG_MIN_DUR;
		cfg_data = '0;
		sent = 0;
		idle_cycles = 0;
		send_quiet = 0;
		recv_quiet = 0;
		hold_req = 0;
		cur_min = MIN_DUR_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: empty query, clamping, raw delete key, widest fields
		send_cmd(KIND_QUERY, 8'h00, 1'b0, 31'd0, 32'd0);
		send_cmd(KIND_ADD, 8'h01, 1'b0, 31'd0, 32'h0000_0001);
		send_cmd(KIND_DEL, 8'h01, 1'b0, 31'd0, 32'd0);
		send_cmd(KIND_DEL, 8'h01, 1'b0, 31'd1000, 32'd0);
		send_cmd(KIND_ADD, 8'hff, 1'b1, 31'h7fff_ffff, 32'hffff_ffff);
		send_cmd(KIND_QUERY, 8'hff, 1'b1, 31'h7fff_ffff, 32'hffff_ffff);
		send_cmd(KIND_TICK, 8'h00, 1'b0, 31'd0, 32'd0);
		send_cmd(KIND_DEL, 8'hff, 1'b1, 31'h7fff_ffff, 32'hffff_ffff);

		// Short timers: silent periodic owner zero, equal deadlines, full store
		write_reg(CFG_MIN_DUR, 20'd1);
		write_reg(CFG_OVERDUE, 20'hffff);
		arm_timer(8'h00, 1'b1, 31'd1, 32'hdead_beef);
		arm_timer(8'h80, 1'b1, 31'd1, 32'h0000_0000);
		arm_timer(8'h03, 1'b0, 31'd1, 32'h5555_aaaa);
		send_cmd(KIND_TICK, 8'h00, 1'b0, 31'd0, 32'd0);
		send_cmd(KIND_TICK, 8'h00, 1'b0, 31'd0, 32'd0);
		send_cmd(KIND_QUERY, 8'h00, 1'b0, 31'd0, 32'd0);
		for (int i = 0; i < 16; i++)
			arm_timer(8'(i + 1), 1'(i), 31'd3, $urandom);
		for (int i = 0; i < 4; i++)
			send_cmd(KIND_TICK, 8'h00, 1'b0, 31'd0, 32'd0);

		// Random part with a long output stall near its start
		hold_req = 1;
		random_cmds(180);

		// Zero minimum acts as one
		write_reg(CFG_MIN_DUR, 20'd0);
		write_reg(CFG_OVERDUE, 20'd0);
		arm_timer(8'h09, 1'b1, 31'd0, 32'h1234_5678);
		send_cmd(KIND_TICK, 8'h00, 1'b0, 31'd0, 32'd0);
		random_cmds(140);

		write_reg(CFG_MIN_DUR, 20'd7);
		write_reg(CFG_OVERDUE, 20'd1234);
		random_cmds(110);

		// Largest minimum
		write_reg(CFG_MIN_DUR, 20'hfffff);
		arm_timer(8'h42, 1'b0, 31'd5, 32'h0f0f_0f0f);
		send_cmd(KIND_QUERY, 8'h00, 1'b0, 31'd0, 32'd0);
		send_cmd(KIND_TICK, 8'h00, 1'b0, 31'd0, 32'd0);
		send_cmd(KIND_DEL, 8'h42, 1'b0, 31'hfffff, 32'd0);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Covered %0d commands (ticks, adds, deletes, queries) over five register",
			sent);
		$display("settings with random gaps and a long output stall; %0d results checked.",
			checked);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
rtl/core/sdtq_pkg.sv
rtl/core/sdtq_cell.sv
rtl/core/sorted_deadline_timer_queue.sv
rtl/core/sdtq_checker.sv
tb/sdtq_checker.sv
tb/tb.sv
